/* rtl/core/clnw_pkg.sv */
// package for the character lcd nibble writer
// holds payload structs, request kind codes, queue sizing and the init table
// no dependencies
package clnw_pkg;

  localparam logic [2:0] KindCmd    = 3'd0;
  localparam logic [2:0] KindChar   = 3'd1;
  localparam logic [2:0] KindPos    = 3'd2;
  localparam logic [2:0] KindNumber = 3'd3;
  localparam logic [2:0] KindClear  = 3'd4;
  localparam logic [2:0] KindInit   = 3'd5;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = QPtrW + 1;

  localparam int unsigned NumDigits = 5;
  localparam int unsigned NumBits   = 16;
  localparam int unsigned BcdW      = 4 * NumDigits;

  localparam logic [7:0] RowOneBase = 8'h7F;  // 0x80 - 1 for one-based column
  localparam logic [7:0] RowTwoBase = 8'hBF;  // 0xc0 - 1
  localparam logic [7:0] CmdClear   = 8'h01;
  localparam logic [7:0] CmdHome    = 8'h80;
  localparam logic [7:0] AsciiZero  = 8'h30;

  localparam logic [3:0] LastSingle = 4'd0;
  localparam logic [3:0] LastClear  = 4'd1;
  localparam logic [3:0] LastInit   = 4'd8;
  localparam logic [3:0] LastNumber = 4'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  byte_value;
    logic [1:0]  row;
    logic [7:0]  col;
    logic [15:0] number;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic       last;
  } qent_t;

  function automatic logic [7:0] init_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h03;
      4'd1:    b = 8'h03;
      4'd2:    b = 8'h03;
      4'd3:    b = 8'h02;
      4'd4:    b = 8'h28;
      4'd5:    b = 8'h08;
      4'd6:    b = 8'h01;
      4'd7:    b = 8'h06;
      4'd8:    b = 8'h0C;
      default: b = 8'h0C;
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/char_lcd_nibble_writer.sv */
// top level of the character lcd nibble writer
// instantiates clnw_front, clnw_queue and clnw_back; depends on clnw_pkg
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid_i/req_ready_o | req_i   (clnw_pkg::req_t)
//  rsp     | out       | rsp_valid_o/rsp_ready_i | rsp_o   (clnw_pkg::rsp_t)
//
// one nibble per cycle while bytes are queued and the receiver is ready; n bytes give
// 2n nibble transfers at the output, and number requests first run a bit-serial
// bcd conversion in the front end before their first byte
// a new request is taken once the front end has queued the previous one's last byte
// reset clears control state only; the queue (4 bytes) lets the front run ahead of stalls
module char_lcd_nibble_writer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  clnw_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output clnw_pkg::rsp_t rsp_o
);

  logic            push_valid;
  logic            push_ready;
  clnw_pkg::qent_t push_data;
  logic            pop_valid;
  logic            pop_ready;
  clnw_pkg::qent_t pop_data;

  clnw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_ready_o  (req_ready_o),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  clnw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  clnw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

endmodule

/* rtl/core/clnw_front.sv */
// front end: takes requests, classifies them and pushes whole bytes to the queue
// runs the binary to bcd conversion for number requests
// depends on clnw_pkg
module clnw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  clnw_pkg::req_t      req_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output clnw_pkg::qent_t     push_data_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [2:0]                   kind_q, kind_d;
  logic [7:0]                   val_q, val_d;
  logic [3:0]                   idx_q, idx_d;
  logic [3:0]                   end_q, end_d;
  logic [3:0]                   bitcnt_q, bitcnt_d;
  logic [clnw_pkg::NumBits-1:0] bin_q, bin_d;
  logic [clnw_pkg::BcdW-1:0]    bcd_q, bcd_d;
  logic [clnw_pkg::BcdW-1:0]    bcd_adj;
  logic [clnw_pkg::BcdW-1:0]    bcd_shift;
  logic [3:0]                   lead;
  logic [3:0]                   digit;
  logic [7:0]                   out_byte;
  logic                         out_rs;
  logic                         req_fire;
  logic                         push_fire;

  assign req_ready_o  = (state_q == StIdle);
  assign req_fire     = req_valid_i && req_ready_o;
  assign push_valid_o = (state_q == StEmit);
  assign push_fire    = push_valid_o && push_ready_i;

  // add-3 adjust before each shift
  always_comb begin
    for (int i = 0; i < clnw_pkg::NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign bcd_shift = {bcd_adj[clnw_pkg::BcdW-2:0], bin_q[clnw_pkg::NumBits-1]};

  // first significant digit, most significant first
  always_comb begin
    priority if (bcd_shift[19:16] != 4'd0) begin
      lead = 4'd0;
    end else if (bcd_shift[15:12] != 4'd0) begin
      lead = 4'd1;
    end else if (bcd_shift[11:8] != 4'd0) begin
      lead = 4'd2;
    end else if (bcd_shift[7:4] != 4'd0) begin
      lead = 4'd3;
    end else begin
      lead = 4'd4;
    end
  end

  always_comb begin
    unique case (idx_q[2:0])
      3'd0:    digit = bcd_q[19:16];
      3'd1:    digit = bcd_q[15:12];
      3'd2:    digit = bcd_q[11:8];
      3'd3:    digit = bcd_q[7:4];
      default: digit = bcd_q[3:0];
    endcase
  end

  always_comb begin
    unique case (kind_q)
      clnw_pkg::KindCmd,
      clnw_pkg::KindChar,
      clnw_pkg::KindPos:    out_byte = val_q;
      clnw_pkg::KindNumber: out_byte = clnw_pkg::AsciiZero | {4'd0, digit};
      clnw_pkg::KindClear:  out_byte = idx_q[0] ? clnw_pkg::CmdHome : clnw_pkg::CmdClear;
      clnw_pkg::KindInit:   out_byte = clnw_pkg::init_byte(idx_q);
      default:              out_byte = val_q;
    endcase
  end

  assign out_rs = (kind_q == clnw_pkg::KindChar) || (kind_q == clnw_pkg::KindNumber);

  assign push_data_o.rs    = out_rs;
  assign push_data_o.value = out_byte;
  assign push_data_o.last  = (idx_q == end_q);

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    val_d    = val_q;
    idx_d    = idx_q;
    end_d    = end_q;
    bitcnt_d = bitcnt_q;
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    unique case (state_q)
      StIdle: begin
        if (req_fire) begin
          kind_d = req_i.req_type;
          idx_d  = 4'd0;
          val_d  = req_i.byte_value;
          unique case (req_i.req_type)
            clnw_pkg::KindCmd,
            clnw_pkg::KindChar: begin
              end_d   = clnw_pkg::LastSingle;
              state_d = StEmit;
            end
            clnw_pkg::KindPos: begin
              end_d = clnw_pkg::LastSingle;
              if (req_i.row == 2'd1) begin
                val_d   = clnw_pkg::RowOneBase + req_i.col;
                state_d = StEmit;
              end else if (req_i.row == 2'd2) begin
                val_d   = clnw_pkg::RowTwoBase + req_i.col;
                state_d = StEmit;
              end
            end
            clnw_pkg::KindNumber: begin
              end_d    = clnw_pkg::LastNumber;
              bin_d    = req_i.number;
              bcd_d    = '0;
              bitcnt_d = 4'd0;
              state_d  = StConv;
            end
            clnw_pkg::KindClear: begin
              end_d   = clnw_pkg::LastClear;
              state_d = StEmit;
            end
            clnw_pkg::KindInit: begin
              end_d   = clnw_pkg::LastInit;
              state_d = StEmit;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StConv: begin
        bcd_d    = bcd_shift;
        bin_d    = {bin_q[clnw_pkg::NumBits-2:0], 1'b0};
        bitcnt_d = 4'(bitcnt_q + 4'd1);
        if (bitcnt_q == 4'(clnw_pkg::NumBits - 1)) begin
          idx_d   = lead;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (push_fire) begin
          idx_d = 4'(idx_q + 4'd1);
          if (idx_q == end_q) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    end_q    <= end_d;
    bitcnt_q <= bitcnt_d;
    bin_q    <= bin_d;
    bcd_q    <= bcd_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (idx_q <= end_q))
    else $error("byte index ran past the last byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StConv && bitcnt_q == 4'(clnw_pkg::NumBits - 1)) |=> (state_q == StEmit))
    else $error("conversion did not hand over to emit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_fire && push_data_o.last) |=> (state_q == StIdle))
    else $error("front kept emitting after the last byte");

endmodule

/* rtl/core/clnw_queue.sv */
// short byte queue between front and back ends
// register-based, clnw_pkg::QueueDepth entries
// depends on clnw_pkg
module clnw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  clnw_pkg::qent_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output clnw_pkg::qent_t pop_data_o
);

  clnw_pkg::qent_t             entry_q [clnw_pkg::QueueDepth];
  logic [clnw_pkg::QPtrW-1:0]  wptr_q, rptr_q;
  logic [clnw_pkg::QCntW-1:0]  count_q;
  logic                        push_fire;
  logic                        pop_fire;

  assign push_ready_o = (count_q != clnw_pkg::QCntW'(clnw_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_fire) begin
        wptr_q <= clnw_pkg::QPtrW'(wptr_q + 1'b1);
      end
      if (pop_fire) begin
        rptr_q <= clnw_pkg::QPtrW'(rptr_q + 1'b1);
      end
      if (push_fire && !pop_fire) begin
        count_q <= clnw_pkg::QCntW'(count_q + 1'b1);
      end else if (pop_fire && !push_fire) begin
        count_q <= clnw_pkg::QCntW'(count_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= clnw_pkg::QCntW'(clnw_pkg::QueueDepth))
    else $error("queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_fire && !pop_fire) |=> (count_q == clnw_pkg::QCntW'($past(count_q) + 1'b1)))
    else $error("queue count missed a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_fire && !push_fire) |=> (count_q == clnw_pkg::QCntW'($past(count_q) - 1'b1)))
    else $error("queue count missed a pop");

endmodule

/* rtl/core/clnw_back.sv */
// back end: splits each queued byte into high and low nibble transfers
// holds the output register
// depends on clnw_pkg
module clnw_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  clnw_pkg::qent_t pop_data_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output clnw_pkg::rsp_t  rsp_o
);

  clnw_pkg::qent_t cur_q;
  logic            valid_q;
  logic            phase_q;  // 0 high nibble, 1 low nibble
  logic            rsp_fire;
  logic            load;

  assign rsp_fire    = valid_q && rsp_ready_i;
  assign load        = !valid_q || (rsp_fire && phase_q);
  assign pop_ready_o = load;

  assign rsp_valid_o      = valid_q;
  assign rsp_o.reg_select = cur_q.rs;
  assign rsp_o.nibble     = phase_q ? cur_q.value[3:0] : cur_q.value[7:4];
  assign rsp_o.last       = cur_q.last && phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (load) begin
      valid_q <= pop_valid_i;
      phase_q <= 1'b0;
    end else if (rsp_fire) begin
      phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && pop_valid_i) begin
      cur_q <= pop_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.last) |-> phase_q)
    else $error("last flagged on a high nibble");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_fire && !phase_q) |=> (valid_q && phase_q))
    else $error("low nibble not presented after high nibble");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> valid_q)
    else $error("low nibble phase without a held byte");

endmodule
